// ----- rtl/core/smbs_pkg.sv -----
// Package for the sorted matrix binary search block.
// Field widths, code constants and the controller/datapath command and status types.
// Used by every module in rtl/core but smbs_ram; depends on nothing.
`default_nettype none

package smbs_pkg;

	// Parameter defaults
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_COLS    = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed port widths
	localparam int FIELD_W   = 32;
	localparam int ROW_IDX_W = 6;
	localparam int COL_IDX_W = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] ROWS_RESET = 7'd0;
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd1;

	// Read address source for the matrix RAM
	typedef enum logic [1:0] {
		ADDR_FIRST,
		ADDR_LAST,
		ADDR_COL
	} addr_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic      wr;
		logic      load;
		logic      row_cap;
		logic      row_step;
		logic      col_init;
		logic      col_step;
		logic      take_low;
		addr_sel_t addr_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic len_zero;
		logic in_span;
		logic first_gt;
		logic val_eq;
		logic val_gt;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/smbs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
`default_nettype none

module smbs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/smbs_datapath.sv -----
// Datapath: configuration registers, matrix RAM, search window and comparators.
// Depends on smbs_pkg and smbs_ram.
`default_nettype none

module smbs_datapath #(
	parameter int MAX_ROWS    = smbs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS    = smbs_pkg::DEF_MAX_COLS,
	parameter int VALUE_WIDTH = smbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]            cfg_data,
	input  logic [smbs_pkg::ROW_IDX_W-1:0]        row_index,
	input  logic [smbs_pkg::COL_IDX_W-1:0]        col_index,
	input  logic signed [smbs_pkg::FIELD_W-1:0]   entry_value,
	input  logic signed [smbs_pkg::FIELD_W-1:0]   search_key,
	input  smbs_pkg::cmd_t                        cmd,
	output smbs_pkg::sts_t                        sts
);

	import smbs_pkg::*;

	localparam int EW    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LW    = $clog2(MAXD + 1);

	logic [CFG_W-1:0]     rows_cfg_q;
	logic [CFG_W-1:0]     cols_cfg_q;
	logic [LW-1:0]        rows_eff;
	logic [LW-1:0]        cols_eff;

	logic signed [EW-1:0] key_q;
	logic signed [EW-1:0] first_q;
	logic [LW-1:0]        cols_q;
	logic [LW-1:0]        base_q;
	logic [LW-1:0]        len_q;
	logic [RW-1:0]        row_q;
	logic [LW-1:0]        mid;

	logic [RW-1:0]        rd_row;
	logic [CW-1:0]        rd_col;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic                 wr_ok;
	logic [EW-1:0]        rdata;
	logic signed [EW-1:0] rval;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ROWS_RESET;
			cols_cfg_q <= COLS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROWS_IN_USE: rows_cfg_q <= cfg_data;
				REG_COLS_IN_USE: cols_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the counts in use; an empty column count reads as one
	always_comb begin
		rows_eff = (32'(rows_cfg_q) > MAX_ROWS) ? LW'(MAX_ROWS) : LW'(rows_cfg_q);
		if (cols_cfg_q == '0) begin
			cols_eff = LW'(1);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			cols_eff = LW'(MAX_COLS);
		end else begin
			cols_eff = LW'(cols_cfg_q);
		end
	end

	assign mid = base_q + (len_q >> 1);

	// Advance the search window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			len_q  <= '0;
		end else if (cmd.load) begin
			base_q <= '0;
			len_q  <= rows_eff;
		end else if (cmd.col_init) begin
			base_q <= '0;
			len_q  <= cols_q;
		end else if (cmd.row_step || cmd.col_step) begin
			if (cmd.take_low) begin
				len_q <= len_q >> 1;
			end else begin
				base_q <= mid + LW'(1);
				len_q  <= len_q - (len_q >> 1) - LW'(1);
			end
		end
	end

	// Hold the query payload and probe results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= search_key[EW-1:0];
			cols_q <= cols_eff;
		end
		if (cmd.row_cap) begin
			first_q <= rval;
		end
		if (cmd.col_init) begin
			row_q <= mid[RW-1:0];
		end
	end

	// Select the read address
	always_comb begin
		case (cmd.addr_sel)
			ADDR_FIRST: begin
				rd_row = mid[RW-1:0];
				rd_col = '0;
			end
			ADDR_LAST: begin
				rd_row = mid[RW-1:0];
				rd_col = CW'(cols_q - LW'(1));
			end
			ADDR_COL: begin
				rd_row = row_q;
				rd_col = CW'(mid);
			end
			default: begin
				rd_row = row_q;
				rd_col = '0;
			end
		endcase
	end

	assign raddr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);
	assign waddr = AW'(RW'(row_index)) * AW'(MAX_COLS) + AW'(CW'(col_index));
	assign wr_ok = cmd.wr && (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);

	smbs_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (waddr),
		.wdata (entry_value[EW-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rval = $signed(rdata);

	// Report window and compare status
	always_comb begin
		sts.len_zero = (len_q == '0);
		sts.first_gt = (first_q > key_q);
		sts.in_span  = (first_q <= key_q) && (rval >= key_q);
		sts.val_eq   = (rval == key_q);
		sts.val_gt   = (rval > key_q);
	end

endmodule

`default_nettype wire

// ----- rtl/core/smbs_ctrl.sv -----
// Controller: sequences the row search and the column search over the single RAM read port.
// Depends on smbs_pkg.
`default_nettype none

module smbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           func,
	input  smbs_pkg::sts_t sts,
	output smbs_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output logic           found
);

	import smbs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW_CHK,
		S_ROW_LAST,
		S_ROW_CMP,
		S_COL_CHK,
		S_COL_CMP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   found_q;
	logic   res_v;
	logic   res_hit;

	// Decode next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_v   = 1'b0;
		res_hit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == FUNC_QUERY) begin
						cmd.load = 1'b1;
						state_d  = S_ROW_CHK;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_ROW_CHK: begin
				if (sts.len_zero) begin
					res_v   = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.addr_sel = ADDR_FIRST;
					state_d      = S_ROW_LAST;
				end
			end
			S_ROW_LAST: begin
				cmd.addr_sel = ADDR_LAST;
				cmd.row_cap  = 1'b1;
				state_d      = S_ROW_CMP;
			end
			S_ROW_CMP: begin
				if (sts.in_span) begin
					cmd.col_init = 1'b1;
					state_d      = S_COL_CHK;
				end else begin
					cmd.row_step = 1'b1;
					cmd.take_low = sts.first_gt;
					state_d      = S_ROW_CHK;
				end
			end
			S_COL_CHK: begin
				if (sts.len_zero) begin
					res_v   = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.addr_sel = ADDR_COL;
					state_d      = S_COL_CMP;
				end
			end
			S_COL_CMP: begin
				if (sts.val_eq) begin
					res_v   = 1'b1;
					res_hit = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.col_step = 1'b1;
					cmd.take_low = sts.val_gt;
					state_d      = S_COL_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_v;
			found_q <= res_v && res_hit;
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign found = found_q;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_matrix_binary_search.sv -----
// Top level of the sorted matrix binary search block.
// Joins smbs_ctrl and smbs_datapath; depends on smbs_pkg.
//
//   channel   signals                                          handshake
//   -------   ----------------------------------------------   -------------------------
//   command   func row_index col_index entry_value search_key  start && !busy
//   result    found                                             done, one cycle, no stall
//   config    cfg_index cfg_data                                cfg_wr_en
//
// A write beat leaves busy low. A query beat keeps busy high for Pr row probes and Pc
// column probes, each at most floor(log2(n)) + 1. A row probe reads its first and
// last entries in turn over the single read port of the matrix RAM. done rises in
// the cycle busy falls; a new command may start in that cycle. Reset clears the
// registers to zero rows and one column; matrix contents are undefined until
// written. The receiver cannot stall a result.
`default_nettype none

module sorted_matrix_binary_search #(
	parameter int MAX_ROWS    = smbs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS    = smbs_pkg::DEF_MAX_COLS,
	parameter int VALUE_WIDTH = smbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [smbs_pkg::ROW_IDX_W-1:0]      row_index,
	input  logic [smbs_pkg::COL_IDX_W-1:0]      col_index,
	input  logic signed [smbs_pkg::FIELD_W-1:0] entry_value,
	input  logic signed [smbs_pkg::FIELD_W-1:0] search_key,
	output logic                                done,
	output logic                                found,
	input  logic                                cfg_wr_en,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]          cfg_data
);

	import smbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	smbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.found  (found)
	);

	smbs_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.row_index   (row_index),
		.col_index   (col_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire

// ----- rtl/core/smbs_checker.sv -----
// Port-level checker for the sorted matrix binary search top level, with its bind.
// Depends on smbs_pkg for the function codes.
`default_nettype none

module smbs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic done,
	input logic found
);

	import smbs_pkg::*;

	// A result beat closes a busy query
	a_done_ends_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result beat without a query in flight");

	// Found is only shown with its strobe
	a_found_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> done)
		else $error("found high outside a result beat");

	// A write beat produces no result and no busy period
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_WRITE) |=> (!busy && !done))
		else $error("write beat caused busy or a result");

	// A query beat goes busy and does not answer in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_QUERY) |=> (busy && !done))
		else $error("query beat did not start a search");

endmodule

bind sorted_matrix_binary_search smbs_checker u_smbs_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_matrix_binary_search: directed table, then random shapes.
// Found flags come from the table or its own copy of matrix and registers; uses smbs_pkg.

module testbench;

	import smbs_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int ITEM_TARGET    = 1550;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 48;
	localparam int TIMEOUT_CYCLES = 800000;
	localparam int ROWS_MAX       = DEF_MAX_ROWS;
	localparam int COLS_MAX       = DEF_MAX_COLS;

	localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum logic { STEP_SHAPE, STEP_BEAT } step_kind_t;

	// one row of the directed table: a register pair or a command beat
	typedef struct packed {
		step_kind_t                kind;
		logic [CFG_W-1:0]          rows;
		logic [CFG_W-1:0]          cols;
		logic                      f;
		logic [ROW_IDX_W-1:0]      row;
		logic [COL_IDX_W-1:0]      col;
		logic signed [FIELD_W-1:0] value;
		logic signed [FIELD_W-1:0] key;
		logic                      typed;
		logic                      typed_found;
	} plan_step_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] key;
		logic                      found;
	} found_exp_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      start       = 1'b0;
	logic                      func        = FUNC_WRITE;
	logic [ROW_IDX_W-1:0]      row_index   = '0;
	logic [COL_IDX_W-1:0]      col_index   = '0;
	logic signed [FIELD_W-1:0] entry_value = '0;
	logic signed [FIELD_W-1:0] search_key  = '0;
	logic                      cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index   = REG_ROWS_IN_USE;
	logic [CFG_W-1:0]          cfg_data    = '0;
	logic                      busy;
	logic                      done;
	logic                      found;

	// predictor state
	int               matrix_copy [ROWS_MAX][COLS_MAX];
	logic [CFG_W-1:0] rows_cfg = ROWS_RESET;
	logic [CFG_W-1:0] cols_cfg = COLS_RESET;

	found_exp_t pending_found [$];
	plan_step_t directed_steps [$];

	int  mismatches   = 0;
	int  results_seen = 0;
	int  items_sent   = 0;
	int  writes_sent  = 0;
	int  queries_sent = 0;
	int  hits_seen    = 0;
	int  shapes_run   = 0;
	bit  calm         = 1'b0;

	sorted_matrix_binary_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.row_index   (row_index),
		.col_index   (col_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.done        (done),
		.found       (found),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// row count in effect: saturates at the matrix height
	function automatic int used_rows();
		return (rows_cfg > ROWS_MAX) ? ROWS_MAX : int'(rows_cfg);
	endfunction

	// column count in effect: zero reads as one, saturates at the matrix width
	function automatic int used_cols();
		if (cols_cfg == 0)
			return 1;
		return (cols_cfg > COLS_MAX) ? COLS_MAX : int'(cols_cfg);
	endfunction

	// row search on first/last entries, then column search inside the matching row
	function automatic logic lookup_key(input int key);
		int nc, base, len, mid, first, last, cb, cl, cm;
		nc = used_cols();
		base = 0;
		len = used_rows();
		while (len > 0) begin
			mid = base + len / 2;
			first = matrix_copy[mid][0];
			last = matrix_copy[mid][nc-1];
			if (first <= key && last >= key) begin
				cb = 0;
				cl = nc;
				while (cl > 0) begin
					cm = cb + cl / 2;
					if (matrix_copy[mid][cm] == key)
						return 1'b1;
					if (matrix_copy[mid][cm] > key) begin
						cl = cl / 2;
					end else begin
						cb = cm + 1;
						cl = cl - cl / 2 - 1;
					end
				end
				return 1'b0;
			end
			if (first > key) begin
				len = len / 2;
			end else begin
				base = mid + 1;
				len = len - len / 2 - 1;
			end
		end
		return 1'b0;
	endfunction

	// hold start low for a random gap about a third of the time
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drive one command beat, wait for it to be taken, then predict its outcome
	task automatic issue(input logic f, input logic [ROW_IDX_W-1:0] r,
			input logic [COL_IDX_W-1:0] c, input logic signed [FIELD_W-1:0] v,
			input logic signed [FIELD_W-1:0] k, input logic typed, input logic typed_found);
		found_exp_t e;
		start <= 1'b1;
		func <= f;
		row_index <= r;
		col_index <= c;
		entry_value <= v;
		search_key <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (f == FUNC_WRITE) begin
			matrix_copy[r][c] = v;
			writes_sent++;
		end else begin
			e.key = k;
			e.found = typed ? typed_found : lookup_key(k);
			pending_found.push_back(e);
			queries_sent++;
		end
		sender_gap();
	endtask

	// stop sending and wait for every pending found flag
	task automatic quiesce();
		start <= 1'b0;
		while (pending_found.size() != 0)
			@(posedge clk);
	endtask

	// write both shape registers once the block is idle
	task automatic set_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ROWS_IN_USE;
		cfg_data <= rows;
		@(posedge clk);
		rows_cfg = rows;
		cfg_index <= REG_COLS_IN_USE;
		cfg_data <= cols;
		@(posedge clk);
		cols_cfg = cols;
		cfg_wr_en <= 1'b0;
		shapes_run++;
	endtask

	// load the whole region in use with ascending values, row-major
	task automatic fill_region();
		int vals [$];
		int nr, nc, n, mode, anchor;
		nr = used_rows();
		nc = used_cols();
		n = nr * nc;
		mode = $urandom_range(0, 2);
		anchor = int'($urandom) / 2;
		for (int i = 0; i < n; i++)
			vals.push_back((mode == 1) ? anchor + int'($urandom_range(0, 2 * n)) : int'($urandom));
		vals.sort();
		// pin the ends to the value extremes
		if (mode == 2 && n > 0) begin
			vals[0] = VAL_MIN;
			vals[n-1] = VAL_MAX;
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				issue(FUNC_WRITE, ROW_IDX_W'(r), COL_IDX_W'(c), vals[r * nc + c], $urandom,
					1'b0, 1'b0);
	endtask

	// mostly stored values and their neighbors, some random and extreme keys
	function automatic int pick_key();
		int sel, v;
		sel = $urandom_range(0, 99);
		if (used_rows() != 0 && sel < 70) begin
			v = matrix_copy[$urandom_range(0, used_rows() - 1)][$urandom_range(0, used_cols() - 1)];
			if (sel >= 50)
				v = $urandom_range(0, 1) ? v + 1 : v - 1;
			return v;
		end
		if (sel < 85)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	// one shape: registers, fill, then queries with stray writes mixed in
	task automatic run_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
			input int beats, input bit mid_pause);
		set_shape(rows, cols);
		fill_region();
		for (int i = 0; i < beats; i++) begin
			if (mid_pause && i == beats / 2)
				quiesce();
			if ($urandom_range(0, 99) < 10)
				issue(FUNC_WRITE, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), $urandom,
					$urandom, 1'b0, 1'b0);
			else
				issue(FUNC_QUERY, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), $urandom,
					pick_key(), 1'b0, 1'b0);
		end
	endtask

	task automatic plan_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		plan_step_t s;
		s = '0;
		s.kind = STEP_SHAPE;
		s.rows = rows;
		s.cols = cols;
		directed_steps.push_back(s);
	endtask

	task automatic plan_beat(input logic f, input logic [ROW_IDX_W-1:0] r,
			input logic [COL_IDX_W-1:0] c, input logic signed [FIELD_W-1:0] v,
			input logic signed [FIELD_W-1:0] k, input logic typed, input logic typed_found);
		plan_step_t s;
		s.kind = STEP_BEAT;
		s.rows = '0;
		s.cols = '0;
		s.f = f;
		s.row = r;
		s.col = c;
		s.value = v;
		s.key = k;
		s.typed = typed;
		s.typed_found = typed_found;
		directed_steps.push_back(s);
	endtask

	// compare each result beat with the oldest pending flag
	always @(posedge clk) begin : check_results
		found_exp_t e;
		if (arst_n && done) begin
			if (pending_found.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing pending, found=%0b", $time, found);
			end else begin
				e = pending_found.pop_front();
				results_seen++;
				if (found)
					hits_seen++;
				if (found !== e.found) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: key %0d expected found=%0b got %0b",
							$time, e.key, e.found, found);
				end
			end
		end
	end

	initial begin : stimulus
		plan_step_t s;

		// no rows after reset: nothing is ever found
		plan_beat(FUNC_QUERY, '0, '0, '0, 0, 1'b1, 1'b0);
		plan_beat(FUNC_QUERY, '1, '1, -1, VAL_MIN, 1'b1, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, VAL_MAX, 1'b1, 1'b0);
		// one row, column count zero reads as one column
		plan_shape(7'd1, 7'd0);
		plan_beat(FUNC_WRITE, '0, '0, VAL_MIN, -1, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '1, '1, VAL_MAX, VAL_MIN, 1'b1, 1'b1);
		plan_beat(FUNC_QUERY, '0, '0, '0, VAL_MAX, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, 0, 1'b0, 1'b0);
		// far corner lies outside the region in use
		plan_beat(FUNC_WRITE, '1, '1, VAL_MAX, '0, 1'b0, 1'b0);
		plan_shape(7'd2, 7'd1);
		plan_beat(FUNC_WRITE, 6'd1, '0, VAL_MAX, '0, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, VAL_MAX, 1'b1, 1'b1);
		plan_beat(FUNC_QUERY, '0, '0, '0, VAL_MIN, 1'b1, 1'b1);
		plan_beat(FUNC_QUERY, '0, '0, '0, -1, 1'b0, 1'b0);
		plan_shape(7'd1, 7'd2);
		plan_beat(FUNC_WRITE, '0, 6'd1, 5, '0, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, 5, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, 6, 1'b0, 1'b0);
		// unsorted row: first entry above last
		plan_beat(FUNC_WRITE, '0, '0, 100, '0, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, 100, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, 5, 1'b0, 1'b0);
		plan_beat(FUNC_WRITE, '0, 6'd1, -1, '0, 1'b0, 1'b0);
		plan_beat(FUNC_QUERY, '0, '0, '0, -1, 1'b0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			if (s.kind == STEP_SHAPE)
				set_shape(s.rows, s.cols);
			else
				issue(s.f, s.row, s.col, s.value, s.key, s.typed, s.typed_found);
		end

		// tall, wide and saturating shapes
		run_shape(7'd127, 7'd1, 60, 1'b0);
		run_shape(7'd1, 7'd100, 60, 1'b0);
		run_shape(7'd64, 7'd2, 60, 1'b1);
		run_shape(7'd2, 7'd127, 60, 1'b0);

		// random small shapes until the beat budget is spent
		for (int p = 0; items_sent < ITEM_TARGET; p++) begin : random_shapes
			int rsel, csel;
			logic [CFG_W-1:0] rows, cols;
			rsel = $urandom_range(0, 99);
			csel = $urandom_range(0, 99);
			rows = (rsel < 10) ? 7'd0 : (rsel < 80) ? CFG_W'($urandom_range(1, 8)) :
				CFG_W'($urandom_range(9, 16));
			cols = (csel < 8) ? 7'd0 : (csel < 80) ? CFG_W'($urandom_range(1, 8)) :
				CFG_W'($urandom_range(9, 16));
			calm = (p == 1);
			run_shape(rows, cols, $urandom_range(40, 90), p == 3);
		end
		calm = 1'b0;

		quiesce();
		repeat (END_CYCLES) @(posedge clk);

		$display("%0d beats: %0d writes, %0d queries, %0d results, %0d found",
			items_sent, writes_sent, queries_sent, results_seen, hits_seen);
		$display("%0d shapes from no rows up to 64 rows and 64 columns, incl. saturated values",
			shapes_run);
		if (mismatches == 0 && pending_found.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatches, pending_found.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results pending", pending_found.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
